FILE: rtl/bws_pkg.sv
// Package: shared widths, config register indices and segment kinds for the waypoint smoother.
`timescale 1ns / 1ps
package bws_pkg;

    localparam int COORD_BITS_DEF  = 24;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int MAX_STEPS_DEF   = 31;
    localparam int W_FRAC_BITS     = 16;
    localparam int STEP_BITS       = 5;
    localparam int GAIN_BITS       = 10;
    localparam int GAIN_MAX        = 512;
    localparam int CFG_IDX_BITS    = 1;
    localparam int CFG_DATA_BITS   = 10;

    localparam logic [CFG_IDX_BITS-1:0] REG_STEPS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN  = 1'b1;

    // segment kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_LINE  = 2'd1;
    localparam logic [1:0] KIND_QUAD  = 2'd2;
    localparam logic [1:0] KIND_CUBIC = 2'd3;

endpackage

FILE: rtl/bws_front.sv
// Front part: waypoint history, length/weight/control computation, hand-off of jobs.
`timescale 1ns / 1ps
module bws_front
    import bws_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] in_x,
    input  logic signed [COORD_BITS-1:0] in_y,
    input  logic                         in_fin,
    input  logic [GAIN_BITS-1:0]         gain,
    // job to back part: first segment (kind a) and second (kind b), then endpoint
    output logic                         job_valid,
    input  logic                         job_stall,
    output logic [1:0]                   job_kind_a,
    output logic [1:0]                   job_kind_b,
    output logic                         job_fin,
    output logic signed [COORD_BITS-1:0] job_pts [12]
);

    localparam int CB  = COORD_BITS;
    localparam int LS  = (CB > 31) ? CB - 31 : 0;
    localparam int MB  = CB - LS;          // magnitude bits
    localparam int SQB = 2 * MB + 2;       // sum of squares, whole bit pairs
    localparam int LB  = MB + 1;           // length bits
    localparam int SB  = LB + 1;           // l1+l2
    localparam int NB  = LB + W_FRAC_BITS; // numerator
    localparam int PB  = CB + 1 + GAIN_BITS + W_FRAC_BITS + 2; // product
    localparam int DEN_SHIFT = 8 + W_FRAC_BITS + 1;

    localparam logic [3:0] ST_IDLE = 4'd0, ST_SQ1 = 4'd1, ST_SQ2 = 4'd2, ST_SQRT = 4'd3,
                           ST_DIV  = 4'd4, ST_MUL = 4'd5, ST_MUL2 = 4'd6, ST_OUT = 4'd7;

    logic [3:0] state_reg, state_next;
    logic [1:0] count_reg, count_next;
    logic signed [CB-1:0] ox_reg, oy_reg, nx_reg, ny_reg, px_reg, py_reg;
    logic signed [CB-1:0] pcx_reg, pcy_reg, bx_reg, by_reg, ax_reg, ay_reg;
    logic fin_reg;
    logic [SQB-1:0] rad_reg;
    logic [LB-1:0]  root_reg, l1_reg;
    logic [SQB-1:0] rem_reg;
    logic [6:0]     it_reg;
    logic           which_reg;
    logic [NB-1:0]  num_reg;
    logic [W_FRAC_BITS:0] w1_reg;
    logic [SB-1:0]  sum_reg;
    logic [NB:0]    drem_reg;
    logic           axis_reg;
    logic signed [PB-1:0] prod_b_reg, prod_a_reg;
    logic signed [CB:0] d_reg;
    logic signed [GAIN_BITS+W_FRAC_BITS+2:0] gw1_reg, gw2_reg;

    // y controls are settled in the first ST_OUT cycle; hold job until then
    logic axis_done_reg;
    logic signed [CB-1:0] ax_ok_x, ax_ok_y, by_cur, ay_cur;
    logic need_y, job_needed, out_go;

    logic signed [CB:0] dxa, dya;
    logic [CB:0] ma, mb;
    logic [MB-1:0] sa, sb;

    logic [GAIN_BITS-1:0] g_eff;
    assign g_eff = (gain > GAIN_BITS'(GAIN_MAX)) ? GAIN_BITS'(GAIN_MAX) : gain;

    assign in_stall = (state_reg != ST_IDLE);

    // segment deltas for the current length
    always_comb
    begin
        if (!which_reg)
        begin
            dxa = (CB+1)'(nx_reg) - (CB+1)'(ox_reg);
            dya = (CB+1)'(ny_reg) - (CB+1)'(oy_reg);
        end
        else
        begin
            dxa = (CB+1)'(px_reg) - (CB+1)'(nx_reg);
            dya = (CB+1)'(py_reg) - (CB+1)'(ny_reg);
        end
        ma = dxa[CB] ? -dxa : dxa;
        mb = dya[CB] ? -dya : dya;
        sa = MB'(ma >> LS);
        sb = MB'(mb >> LS);
    end

    logic [SQB-1:0] rem_sh;
    logic [NB:0]    dtrial;
    logic signed [PB-1:0] round_b, round_a;
    logic signed [CB+1:0] cb_full, ca_full;
    logic signed [CB-1:0] cmid;

    function automatic logic signed [PB-1:0] rnd_shift(input logic signed [PB-1:0] v);
        logic [PB-1:0] m;
        m = v[PB-1] ? -v : v;
        m = (m + (PB'(1) << (DEN_SHIFT - 1))) >> DEN_SHIFT;
        return v[PB-1] ? -m : m;
    endfunction

    function automatic logic signed [CB-1:0] sat(input logic signed [CB+1:0] v);
        logic signed [CB+1:0] hi, lo;
        hi = (CB+2)'({1'b0, {(CB-1){1'b1}}});
        lo = -hi - (CB+2)'(1);
        if (v > hi) return CB'(hi);
        if (v < lo) return CB'(lo);
        return CB'(v);
    endfunction

    always_comb
    begin
        rem_sh  = {rem_reg[SQB-3:0], rad_reg[SQB-1:SQB-2]};
        dtrial  = {drem_reg[NB-1:0], num_reg[NB-1]};
        round_b = rnd_shift(prod_b_reg);
        round_a = rnd_shift(prod_a_reg);
        // x products are folded in ST_MUL, y products in the first ST_OUT cycle
        cmid    = (state_reg == ST_OUT) ? ny_reg : nx_reg;
        cb_full = (CB+2)'(cmid) - (CB+2)'(round_b);
        ca_full = (CB+2)'(cmid) + (CB+2)'(round_a);
    end

    logic [SQB-1:0] root_ext;
    assign root_ext = SQB'(root_reg);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = (count_reg >= 2'd2) ? ST_SQ1 : ST_OUT;
            end
            ST_SQ1:  state_next = ST_SQRT;
            ST_SQ2:  state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (it_reg == 7'(SQB/2))
                    state_next = which_reg ? ST_DIV : ST_SQ2;
            end
            ST_DIV:
            begin
                if (sum_reg == '0 || it_reg == 7'(NB))
                    state_next = (sum_reg == '0) ? ST_OUT : ST_MUL;
            end
            ST_MUL:  state_next = ST_MUL2;
            ST_MUL2: state_next = axis_reg ? ST_OUT : ST_MUL;
            ST_OUT:
            begin
                if (out_go)
                begin
                    state_next = ST_IDLE;
                    if (fin_reg)
                        count_next = 2'd0;
                    else if (count_reg != 2'd3)
                        count_next = count_reg + 2'd1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    px_reg    <= in_x;
                    py_reg    <= in_y;
                    fin_reg   <= in_fin;
                    which_reg <= 1'b0;
                    axis_reg  <= 1'b0;
                end
            end
            ST_SQ1, ST_SQ2:
            begin
                rad_reg  <= SQB'(sa) * SQB'(sa) + SQB'(sb) * SQB'(sb);
                rem_reg  <= '0;
                root_reg <= '0;
                it_reg   <= '0;
            end
            ST_SQRT:
            begin
                if (it_reg == 7'(SQB/2))
                begin
                    if (!which_reg) l1_reg <= root_reg;
                    else
                    begin
                        sum_reg  <= SB'(l1_reg) + SB'(root_reg);
                        num_reg  <= NB'(l1_reg) << W_FRAC_BITS;
                        drem_reg <= '0;
                        w1_reg   <= '0;
                        it_reg   <= '0;
                    end
                    which_reg <= 1'b1;
                end
                else
                begin
                    rad_reg <= rad_reg << 2;
                    it_reg  <= it_reg + 7'd1;
                    if (rem_sh >= ((root_ext << 2) | SQB'(1)))
                    begin
                        rem_reg  <= rem_sh - ((root_ext << 2) | SQB'(1));
                        root_reg <= {root_reg[LB-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[LB-2:0], 1'b0};
                    end
                end
            end
            ST_DIV:
            begin
                if (sum_reg == '0)
                begin
                    bx_reg <= nx_reg; by_reg <= ny_reg;
                    ax_reg <= nx_reg; ay_reg <= ny_reg;
                end
                else if (it_reg == 7'(NB))
                begin
                    // rounding: remainder*2 >= sum
                    if (({drem_reg, 1'b0}) >= (NB+2)'(sum_reg))
                        w1_reg <= w1_reg + 1'b1;
                    d_reg <= (CB+1)'(px_reg) - (CB+1)'(ox_reg);
                end
                else
                begin
                    num_reg <= num_reg << 1;
                    it_reg  <= it_reg + 7'd1;
                    if (dtrial >= (NB+1)'(sum_reg))
                    begin
                        drem_reg <= dtrial - (NB+1)'(sum_reg);
                        w1_reg   <= (W_FRAC_BITS+1)'({w1_reg, 1'b1});
                    end
                    else
                    begin
                        drem_reg <= dtrial;
                        w1_reg   <= (W_FRAC_BITS+1)'({w1_reg, 1'b0});
                    end
                end
            end
            ST_MUL:
            begin
                gw1_reg <= $signed({1'b0, g_eff}) * $signed({1'b0, w1_reg});
                gw2_reg <= $signed({1'b0, g_eff})
                         * $signed({1'b0, (W_FRAC_BITS+1)'(1 << W_FRAC_BITS) - w1_reg});
                if (axis_reg)
                    d_reg <= (CB+1)'(py_reg) - (CB+1)'(oy_reg);
            end
            ST_MUL2:
            begin
                // ST_MUL2: scale by delta, controls formed next pass
                prod_b_reg <= PB'(gw1_reg) * PB'(d_reg);
                prod_a_reg <= PB'(gw2_reg) * PB'(d_reg);
                axis_reg   <= 1'b1;
            end
            default: ;
        endcase
        // control result registered in the cycle after products land
        if (state_reg == ST_MUL && axis_reg)
        begin
            bx_reg <= sat(cb_full);
            ax_reg <= sat(ca_full);
        end
        if (state_reg == ST_OUT && sum_reg != '0 && count_reg >= 2'd2 && !axis_done_reg)
        begin
            by_reg <= sat(cb_full);
            ay_reg <= sat(ca_full);
        end
        if (out_go)
        begin
            if (count_reg >= 2'd2)
            begin
                pcx_reg <= ax_ok_x;
                pcy_reg <= ax_ok_y;
            end
            if (!fin_reg)
            begin
                ox_reg <= nx_reg; oy_reg <= ny_reg;
                nx_reg <= px_reg; ny_reg <= py_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            axis_done_reg <= 1'b0;
        else
            axis_done_reg <= (state_reg == ST_OUT) && !out_go;
    end

    assign ax_ok_x = ax_reg;
    assign ax_ok_y = ay_reg;
    assign by_cur  = by_reg;
    assign ay_cur  = ay_reg;

    assign need_y = (count_reg >= 2'd2) && !axis_done_reg;

    // a waypoint with fewer than two before it and not final makes no results
    assign job_needed = (count_reg >= 2'd2) || fin_reg;
    assign out_go     = (state_reg == ST_OUT) && !need_y && (!job_needed || !job_stall);

    assign job_valid = (state_reg == ST_OUT) && !need_y && job_needed;
    assign job_fin   = fin_reg;

    always_comb
    begin
        job_kind_a = KIND_NONE;
        job_kind_b = KIND_NONE;
        if (count_reg == 2'd2) job_kind_a = KIND_QUAD;
        if (count_reg == 2'd3) job_kind_a = KIND_CUBIC;
        if (fin_reg)
        begin
            if (count_reg == 2'd1) job_kind_b = KIND_LINE;
            if (count_reg >= 2'd2) job_kind_b = KIND_QUAD;
        end
        // segment a: older, c1, c2, newer
        job_pts[0] = ox_reg;  job_pts[1] = oy_reg;
        job_pts[2] = (count_reg == 2'd3) ? pcx_reg : bx_reg;
        job_pts[3] = (count_reg == 2'd3) ? pcy_reg : by_cur;
        job_pts[4] = bx_reg;  job_pts[5] = by_cur;
        job_pts[6] = nx_reg;  job_pts[7] = ny_reg;
        // segment b: newer, control, endpoint
        job_pts[8]  = (count_reg >= 2'd2) ? ax_reg : nx_reg;
        job_pts[9]  = (count_reg >= 2'd2) ? ay_cur : ny_reg;
        job_pts[10] = px_reg;
        job_pts[11] = py_reg;
    end

endmodule

FILE: rtl/bws_back.sv
// Back part: job queue and curve sampler by repeated linear interpolation.
`timescale 1ns / 1ps
module bws_back
    import bws_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         job_valid,
    output logic                         job_stall,
    input  logic [1:0]                   job_kind_a,
    input  logic [1:0]                   job_kind_b,
    input  logic                         job_fin,
    input  logic signed [COORD_BITS-1:0] job_pts [12],
    input  logic [STEP_BITS-1:0]         steps,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         run_end,
    output logic                         path_end
);

    localparam int CB = COORD_BITS;
    localparam int TB = T_FRAC_BITS;
    localparam int PW = CB + TB + 3;
    localparam int TN = STEP_BITS + TB + 1;   // dividend bits of j*2^TB

    localparam logic [2:0] SB_IDLE = 3'd0, SB_T = 3'd1, SB_L1 = 3'd2, SB_L2 = 3'd3,
                           SB_L3 = 3'd4, SB_PUT = 3'd5, SB_END = 3'd6;

    // one-entry job queue
    logic        q_full_reg;
    logic [1:0]  qa_reg, qb_reg, kind_reg;
    logic        qf_reg;
    logic signed [CB-1:0] q_reg [12];

    logic [2:0]  st_reg;
    logic        seg_reg;         // 0: segment a, 1: segment b
    logic [STEP_BITS-1:0] j_reg, s_eff;
    logic [TB:0] t_reg;
    logic [STEP_BITS+TB:0] tdrem_reg;
    logic [4:0]  tit_reg;
    logic        ax_reg;          // axis 0 x, 1 y
    logic signed [CB+1:0] v_reg [4];
    logic signed [CB+1:0] rx_reg;
    logic        ob_full_reg;

    assign job_stall = q_full_reg;

    assign s_eff = (steps == '0) ? STEP_BITS'(1)
                 : (steps > STEP_BITS'(MAX_STEPS)) ? STEP_BITS'(MAX_STEPS) : steps;

    function automatic logic signed [CB+1:0] lerp(input logic signed [CB+1:0] a,
                                                 input logic signed [CB+1:0] b,
                                                 input logic [TB:0] t);
        logic signed [PW-1:0] p;
        logic [PW-1:0] m;
        p = PW'(b - a) * $signed({1'b0, t});
        m = p[PW-1] ? -p : p;
        m = (m + (PW'(1) << (TB - 1))) >> TB;
        return a + (CB+2)'(p[PW-1] ? -m : m);
    endfunction

    function automatic logic signed [CB-1:0] sat(input logic signed [CB+1:0] v);
        logic signed [CB+1:0] hi, lo;
        hi = (CB+2)'({1'b0, {(CB-1){1'b1}}});
        lo = -hi - (CB+2)'(1);
        if (v > hi) return CB'(hi);
        if (v < lo) return CB'(lo);
        return CB'(v);
    endfunction

    logic out_free;
    assign out_free = !ob_full_reg || !out_stall;
    assign out_valid = ob_full_reg;

    logic ob_load;
    assign ob_load = out_free && ((st_reg == SB_PUT && ax_reg) || st_reg == SB_END);

    logic last_sample, has_b;
    assign last_sample = (j_reg == s_eff - STEP_BITS'(1)) && ax_reg;
    assign has_b = (qb_reg != KIND_NONE);

    logic [STEP_BITS+TB:0] tnum;
    assign tnum = (STEP_BITS+TB+1)'(j_reg) << TB;

    function automatic logic signed [CB+1:0] ext(input logic signed [CB-1:0] v);
        return (CB+2)'(v);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_full_reg  <= 1'b0;
            st_reg      <= SB_IDLE;
            ob_full_reg <= 1'b0;
        end
        else
        begin
            ob_full_reg <= ob_load || (ob_full_reg && out_stall);
            if (job_valid && !q_full_reg)
                q_full_reg <= 1'b1;
            unique case (st_reg)
                SB_IDLE:
                begin
                    if (q_full_reg)
                    begin
                        if (qa_reg != KIND_NONE) st_reg <= SB_T;
                        else if (has_b)          st_reg <= SB_T;
                        else                     st_reg <= SB_END;
                    end
                end
                SB_T:
                begin
                    if (tit_reg == 5'(TN)) st_reg <= SB_L1;
                end
                SB_L1: st_reg <= (kind_reg == KIND_LINE) ? SB_PUT : SB_L2;
                SB_L2: st_reg <= (kind_reg == KIND_QUAD) ? SB_PUT : SB_L3;
                SB_L3: st_reg <= SB_PUT;
                SB_PUT:
                begin
                    if (out_free)
                    begin
                        if (!ax_reg) st_reg <= SB_L1;
                        else if (!last_sample) st_reg <= SB_T;
                        else if (!seg_reg && has_b) st_reg <= SB_T;
                        else if (qf_reg) st_reg <= SB_END;
                        else
                        begin
                            st_reg     <= SB_IDLE;
                            q_full_reg <= 1'b0;
                        end
                    end
                end
                SB_END:
                begin
                    if (out_free)
                    begin
                        st_reg      <= SB_IDLE;
                        q_full_reg  <= 1'b0;
                    end
                end
                default: st_reg <= SB_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid && !q_full_reg)
        begin
            qa_reg <= job_kind_a;
            qb_reg <= job_kind_b;
            qf_reg <= job_fin;
            q_reg  <= job_pts;
        end
        unique case (st_reg)
            SB_IDLE:
            begin
                seg_reg   <= (qa_reg == KIND_NONE);
                kind_reg  <= (qa_reg == KIND_NONE) ? qb_reg : qa_reg;
                j_reg     <= '0;
                ax_reg    <= 1'b0;
                tit_reg   <= '0;
                tdrem_reg <= '0;
                t_reg     <= '0;
            end
            SB_T:
            begin
                // restoring divide: t = round(j*2^TB / s), one dividend bit a cycle
                if (tit_reg == 5'(TN))
                begin
                    if ({tdrem_reg[STEP_BITS:0], 1'b0} >= (STEP_BITS+2)'(s_eff))
                        t_reg <= t_reg + 1'b1;
                end
                else
                begin
                    tit_reg <= tit_reg + 5'd1;
                    if ({tdrem_reg[STEP_BITS-1:0], tnum[5'(TN - 1) - tit_reg]}
                        >= (STEP_BITS+1)'(s_eff))
                    begin
                        tdrem_reg <= (STEP_BITS+TB+1)'(
                            {tdrem_reg[STEP_BITS-1:0], tnum[5'(TN - 1) - tit_reg]}
                            - (STEP_BITS+1)'(s_eff));
                        t_reg <= {t_reg[TB-1:0], 1'b1};
                    end
                    else
                    begin
                        tdrem_reg <= (STEP_BITS+TB+1)'(
                            {tdrem_reg[STEP_BITS-1:0], tnum[5'(TN - 1) - tit_reg]});
                        t_reg <= {t_reg[TB-1:0], 1'b0};
                    end
                end
            end
            SB_L1:
            begin
                if (!seg_reg)
                begin
                    v_reg[0] <= lerp(ext(q_reg[4'(ax_reg)]),
                                     ext(q_reg[4'(2) + 4'(ax_reg)]), t_reg);
                    v_reg[1] <= lerp(ext(q_reg[4'(2) + 4'(ax_reg)]),
                                     ext(q_reg[4'(kind_reg == KIND_QUAD ? 6 : 4)
                                              + 4'(ax_reg)]), t_reg);
                    v_reg[2] <= lerp(ext(q_reg[4'(4) + 4'(ax_reg)]),
                                     ext(q_reg[4'(6) + 4'(ax_reg)]), t_reg);
                end
                else
                begin
                    // segment b: newer point, control, endpoint
                    v_reg[0] <= lerp(ext(q_reg[4'(6) + 4'(ax_reg)]),
                                     ext(q_reg[4'(8) + 4'(ax_reg)]), t_reg);
                    v_reg[1] <= lerp(ext(q_reg[4'(8) + 4'(ax_reg)]),
                                     ext(q_reg[4'(10) + 4'(ax_reg)]), t_reg);
                    v_reg[2] <= '0;
                end
                if (kind_reg == KIND_LINE)
                    rx_reg <= lerp(ext(q_reg[4'(8) + 4'(ax_reg)]),
                                   ext(q_reg[4'(10) + 4'(ax_reg)]), t_reg);
            end
            SB_L2:
            begin
                v_reg[0] <= lerp(v_reg[0], v_reg[1], t_reg);
                v_reg[1] <= lerp(v_reg[1], v_reg[2], t_reg);
                rx_reg   <= lerp(v_reg[0], v_reg[1], t_reg);
            end
            SB_L3: rx_reg <= lerp(v_reg[0], v_reg[1], t_reg);
            SB_PUT:
            begin
                if (out_free)
                begin
                    if (!ax_reg) point_x <= sat(rx_reg);
                    else
                    begin
                        point_y  <= sat(rx_reg);
                        run_end  <= last_sample && (seg_reg || !has_b) && !qf_reg;
                        path_end <= 1'b0;
                        tit_reg  <= '0; tdrem_reg <= '0; t_reg <= '0;
                        if (!last_sample) j_reg <= j_reg + 1'b1;
                        else
                        begin
                            j_reg    <= '0;
                            seg_reg  <= 1'b1;
                            kind_reg <= qb_reg;
                        end
                    end
                    ax_reg <= !ax_reg;
                end
            end
            SB_END:
            begin
                if (out_free)
                begin
                    point_x  <= q_reg[10];
                    point_y  <= q_reg[11];
                    run_end  <= 1'b1;
                    path_end <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (rst_n && out_valid && path_end)
            assert (run_end) else $error("path end without run end");
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped while stalled");
    a_q: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != SB_IDLE) |-> q_full_reg)
        else $error("sampler busy without job");
    a_end: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == SB_END) |-> qf_reg)
        else $error("endpoint without final waypoint");

endmodule

FILE: rtl/bezier_waypoint_smoother.sv
// Top level of the Bezier waypoint smoother.
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | waypoint_x, waypoint_y, is_final_waypoint
//  out     | output    | out_valid/out_stall  | point_x, point_y, run_end, path_end
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
// Per waypoint with two before it the front part computes two lengths by bit-serial
// square roots, divides for the weight, then forms products and hands off the job;
// other waypoints go straight to the output state.
// For each sample the back part divides bit-serially for t, then interpolates each
// axis as the segment kind needs; output stalls hold the sampler.
// The one-entry job queue lets the front work on the next waypoint while the
// back samples. Reset: count cleared, steps 10, gain 256.
`timescale 1ns / 1ps
module bezier_waypoint_smoother
    import bws_pkg::*;
#(
    parameter int COORD_BITS  = COORD_BITS_DEF,
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF,
    parameter int MAX_STEPS   = MAX_STEPS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic signed [COORD_BITS-1:0] waypoint_x,
    input  logic signed [COORD_BITS-1:0] waypoint_y,
    input  logic                         is_final_waypoint,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic signed [COORD_BITS-1:0] point_x,
    output logic signed [COORD_BITS-1:0] point_y,
    output logic                         run_end,
    output logic                         path_end,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  logic [CFG_DATA_BITS-1:0]     cfg_data
);

    logic [STEP_BITS-1:0] steps_reg;
    logic [GAIN_BITS-1:0] gain_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= STEP_BITS'(10);
            gain_reg  <= GAIN_BITS'(256);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEPS: steps_reg <= cfg_data[STEP_BITS-1:0];
                REG_GAIN:  gain_reg  <= cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic                         job_valid, job_stall, job_fin;
    logic [1:0]                   job_kind_a, job_kind_b;
    logic signed [COORD_BITS-1:0] job_pts [12];

    bws_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_x       (waypoint_x),
        .in_y       (waypoint_y),
        .in_fin     (is_final_waypoint),
        .gain       (gain_reg),
        .job_valid  (job_valid),
        .job_stall  (job_stall),
        .job_kind_a (job_kind_a),
        .job_kind_b (job_kind_b),
        .job_fin    (job_fin),
        .job_pts    (job_pts)
    );

    bws_back #(
        .COORD_BITS  (COORD_BITS),
        .T_FRAC_BITS (T_FRAC_BITS),
        .MAX_STEPS   (MAX_STEPS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_valid  (job_valid),
        .job_stall  (job_stall),
        .job_kind_a (job_kind_a),
        .job_kind_b (job_kind_b),
        .job_fin    (job_fin),
        .job_pts    (job_pts),
        .steps      (steps_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .point_x    (point_x),
        .point_y    (point_y),
        .run_end    (run_end),
        .path_end   (path_end)
    );

endmodule
